// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of the level meter.
// Depends on nothing; each macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define ACM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under an active-low reset.
`define ACM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/acm_pkg.sv =====
// Package of the audio chunk level meter: codes, state types, constants.
// Used by the top level and by the shared arithmetic unit.
package acm_pkg;

	localparam int HistDepth = 1024;
	localparam int HistAw = 10;
	localparam logic [12:0] MAX_CHUNK = 13'd4096;
	localparam logic [10:0] HIST_DEPTH_W = 11'd1024;
	localparam logic signed [15:0] DB_FLOOR = -16'sd25600;
	localparam logic [26:0] DB_GAIN = 27'd101008905;
	localparam logic [27:0] LOG_FULL = 28'd251658240;
	localparam logic [14:0] DB_MAG_MAX = 15'd25600;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_EMPTY  = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CFG_HIST_LIMIT = 2'd0,
		CFG_CLIP_THR   = 2'd1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_START,
		ST_MATH,
		ST_RDWAIT,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		M_IDLE,
		M_DIV,
		M_SQRT,
		M_LOG,
		M_DB,
		M_DONE
	} mstate_t;

	typedef struct packed {
		logic        start;
		logic [15:0] peak;
		logic [42:0] sum;
		logic [12:0] count;
	} math_req_t;

	typedef struct packed {
		logic               done;
		logic [15:0]        rms;
		logic signed [15:0] dbfs;
	} math_rsp_t;

	function automatic logic [3:0] floor_log2(input logic [15:0] v);
		logic [3:0] e;
		e = 4'd0;
		for (int i = 1; i < 16; i++) begin
			if (v[i]) e = 4'(i);
		end
		return e;
	endfunction

endpackage

// ===== hdl/acm_math.sv =====
// Shared iterative arithmetic unit: restoring divide, digit-by-digit root
// and squaring log2 with dB scaling. Depends on acm_pkg.
module acm_math import acm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  math_req_t req,
	output math_rsp_t rsp
);

	mstate_t     mst_q;
	logic [5:0]  cnt_q;
	logic [12:0] div_q;
	logic [42:0] dq_q;
	logic [13:0] rem_q;
	logic [31:0] sx_q;
	logic [17:0] srem_q;
	logic [15:0] root_q;
	logic [15:0] peak_q;
	logic [3:0]  e_q;
	logic [30:0] m_q;
	logic [23:0] frac_q;
	logic [54:0] dprod_q;
	logic signed [15:0] dbfs_q;
	logic        done_q;

	logic [13:0] div_r;
	logic        div_ge;
	logic [19:0] sq_r;
	logic [19:0] sq_t;
	logic        sq_ge;
	logic [61:0] lprod;
	logic [31:0] lt;
	logic [27:0] lval;
	logic [27:0] dval;
	logic [55:0] dround;
	logic [15:0] dmag;
	logic [3:0]  e_in;

	always_comb begin
		div_r  = {rem_q[12:0], dq_q[42]};
		div_ge = div_r >= {1'b0, div_q};
		sq_r   = {srem_q, sx_q[31:30]};
		sq_t   = {2'b00, root_q, 2'b01};
		sq_ge  = sq_r >= sq_t;
		lprod  = 62'(m_q) * 62'(m_q);
		lt     = lprod[61:30];
		lval   = {e_q, frac_q};
		dval   = (lval >= LOG_FULL) ? 28'd0 : LOG_FULL - lval;
		dround = {1'b0, dprod_q} + (56'd1 << 39);
		dmag   = dround[55:40];
		e_in   = floor_log2(req.peak);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mst_q  <= M_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (mst_q)
				M_IDLE: begin
					if (req.start) begin
						mst_q <= M_DIV;
						cnt_q <= 6'd42;
					end
				end
				M_DIV: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd0) begin
						mst_q <= M_SQRT;
						cnt_q <= 6'd15;
					end
				end
				M_SQRT: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd0) begin
						mst_q <= M_LOG;
						cnt_q <= 6'd23;
					end
				end
				M_LOG: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd0) mst_q <= M_DB;
				end
				M_DB: mst_q <= M_DONE;
				M_DONE: begin
					mst_q  <= M_IDLE;
					done_q <= 1'b1;
				end
				default: mst_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (mst_q)
			M_IDLE: begin
				if (req.start) begin
					div_q  <= req.count;
					dq_q   <= req.sum;
					rem_q  <= '0;
					peak_q <= req.peak;
					e_q    <= e_in;
					m_q    <= 31'({15'd0, req.peak} << (5'd30 - {1'b0, e_in}));
					frac_q <= '0;
				end
			end
			M_DIV: begin
				if (div_ge) rem_q <= div_r - {1'b0, div_q};
				else rem_q <= div_r;
				dq_q <= {dq_q[41:0], div_ge};
				if (cnt_q == 6'd0) begin
					sx_q   <= {1'b0, dq_q[29:0], div_ge};
					srem_q <= '0;
					root_q <= '0;
				end
			end
			M_SQRT: begin
				if (sq_ge) srem_q <= 18'(sq_r - sq_t);
				else srem_q <= sq_r[17:0];
				root_q <= {root_q[14:0], sq_ge};
				sx_q   <= {sx_q[29:0], 2'b00};
			end
			M_LOG: begin
				frac_q <= {frac_q[22:0], lt[31]};
				m_q    <= lt[31] ? lt[31:1] : lt[30:0];
			end
			M_DB: dprod_q <= 55'(dval) * 55'(DB_GAIN);
			M_DONE: begin
				if (peak_q == 16'd0 || dmag > {1'b0, DB_MAG_MAX}) dbfs_q <= DB_FLOOR;
				else dbfs_q <= -$signed(dmag);
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.rms  = root_q;
	assign rsp.dbfs = dbfs_q;

endmodule

// ===== hdl/audio_chunk_level_meter.sv =====
// Top level of the audio chunk level meter: handshakes, chunk accumulators,
// history ring memory and result register. Depends on acm_pkg and acm_math.
//
// Channel   Direction  Handshake            Carries
// in        input      in_valid/in_ready    operation, sample, last_in_chunk, read_index
// out       output     out_valid/out_ready  one meter or history read result
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// A sample that is not last passes the accumulate state, a clear is taken in idle, a
// history read passes the read-wait and emit states. A last sample also runs 43 divide
// steps, 16 root steps and 24 squaring steps of the shared arithmetic unit.
// Reset clears all control state; the history memory needs no clearing pass.
// A request that gives a result waits in its final cycle while the result
// register still holds an untaken result.
module audio_chunk_level_meter import acm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic signed [15:0] sample,
	input  logic               last_in_chunk,
	input  logic [9:0]         read_index,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               result_kind,
	output logic [15:0]        peak,
	output logic [15:0]        rms,
	output logic signed [15:0] dbfs,
	output logic               clipping,
	output logic signed [15:0] envelope_min,
	output logic signed [15:0] envelope_max,
	output logic [10:0]        history_count,
	output logic               chunk_overflow,
	output logic               index_valid,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	state_t state_q, state_d;
	op_t    op_q;
	logic signed [15:0] sample_q;
	logic        last_q;
	logic [9:0]  idx_q;
	logic        rd_ok_q;
	logic [10:0] limit_q;
	logic [15:0] clip_q;
	logic [15:0] pacc_q;
	logic [42:0] sum_q;
	logic signed [15:0] min_q, max_q;
	logic [12:0] cnt_q;
	logic        ovf_q;
	logic [9:0]  head_q;
	logic [10:0] fill_q;
	logic [15:0] mpeak_q, mrms_q;
	logic signed [15:0] mdbfs_q;
	logic        mclip_q;
	logic [31:0] mem_q [HistDepth];
	logic [31:0] rd_q;
	logic        ov_q;
	logic        kind_q, clipo_q, ovfo_q, ivo_q;
	logic [15:0] peako_q, rmso_q;
	logic signed [15:0] dbfso_q, mino_q, maxo_q;
	logic [10:0] cnto_q;

	logic        in_fire, emit_fire, acc_fire, math_start;
	logic [15:0] mag;
	logic [31:0] mag_sq;
	logic [10:0] lim;
	logic        full;
	logic [9:0]  wpos, head1, head_new;
	logic [10:0] fill1, fill_new;
	math_req_t   mreq;
	math_rsp_t   mrsp;

	acm_math u_math (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		emit_fire  = 1'b0;
		acc_fire   = 1'b0;
		math_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (op_t'(operation))
						OP_SAMPLE: state_d = ST_ACC;
						OP_EMPTY:  state_d = ST_EMIT;
						OP_CLEAR:  state_d = ST_IDLE;
						OP_READ:   state_d = ST_RDWAIT;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_ACC: begin
				acc_fire = 1'b1;
				if (last_q) state_d = ST_START;
				else state_d = ST_IDLE;
			end
			ST_START: begin
				math_start = 1'b1;
				state_d    = ST_MATH;
			end
			ST_MATH: if (mrsp.done) state_d = ST_EMIT;
			ST_RDWAIT: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!ov_q || out_ready) begin
					emit_fire = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_fire   = in_valid && in_ready;
		cfg_ready = 1'b1;
		mag       = sample_q[15] ? 16'(-sample_q) : 16'(sample_q);
		mag_sq    = mag * mag;
		lim       = (limit_q > HIST_DEPTH_W) ? HIST_DEPTH_W : limit_q;
		full      = fill_q >= HIST_DEPTH_W;
		wpos      = full ? head_q : head_q + fill_q[9:0];
		head1     = full ? head_q + 10'd1 : head_q;
		fill1     = full ? fill_q : fill_q + 11'd1;
		if (fill1 > lim) begin
			head_new = head1 + 10'(fill1 - lim);
			fill_new = lim;
		end else begin
			head_new = head1;
			fill_new = fill1;
		end
		mreq.start = math_start;
		mreq.peak  = pacc_q;
		mreq.sum   = sum_q;
		mreq.count = cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			limit_q <= 11'd1024;
			clip_q  <= 16'd32736;
			pacc_q  <= '0;
			sum_q   <= '0;
			min_q   <= 16'sh7fff;
			max_q   <= -16'sh8000;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			head_q  <= '0;
			fill_q  <= '0;
			mpeak_q <= '0;
			mrms_q  <= '0;
			mdbfs_q <= DB_FLOOR;
			mclip_q <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_HIST_LIMIT: limit_q <= cfg_data[10:0];
					CFG_CLIP_THR:   clip_q  <= cfg_data;
					default: ;
				endcase
			end
			if (in_fire && op_t'(operation) == OP_CLEAR) begin
				head_q  <= '0;
				fill_q  <= '0;
				mpeak_q <= '0;
				mrms_q  <= '0;
				mdbfs_q <= DB_FLOOR;
				mclip_q <= 1'b0;
			end
			if (acc_fire) begin
				if (cnt_q < MAX_CHUNK) begin
					if (mag > pacc_q) pacc_q <= mag;
					sum_q <= sum_q + {11'd0, mag_sq};
					if (sample_q < min_q) min_q <= sample_q;
					if (sample_q > max_q) max_q <= sample_q;
					cnt_q <= cnt_q + 13'd1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (out_valid && out_ready) ov_q <= 1'b0;
			if (emit_fire) begin
				ov_q <= 1'b1;
				if (op_q == OP_SAMPLE || op_q == OP_EMPTY) begin
					pacc_q <= '0;
					sum_q  <= '0;
					min_q  <= 16'sh7fff;
					max_q  <= -16'sh8000;
					cnt_q  <= '0;
					ovf_q  <= 1'b0;
				end
				if (op_q == OP_SAMPLE) begin
					mpeak_q <= pacc_q;
					mrms_q  <= mrsp.rms;
					mdbfs_q <= mrsp.dbfs;
					mclip_q <= pacc_q >= clip_q;
					head_q  <= head_new;
					fill_q  <= fill_new;
				end else if (op_q == OP_EMPTY) begin
					mpeak_q <= '0;
					mrms_q  <= '0;
					mdbfs_q <= DB_FLOOR;
					mclip_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q     <= op_t'(operation);
			sample_q <= sample;
			last_q   <= last_in_chunk;
			idx_q    <= read_index;
			rd_ok_q  <= {1'b0, read_index} < fill_q;
		end
		if (emit_fire) begin
			case (op_q)
				OP_SAMPLE: begin
					kind_q  <= 1'b0;
					peako_q <= pacc_q;
					rmso_q  <= mrsp.rms;
					dbfso_q <= mrsp.dbfs;
					clipo_q <= pacc_q >= clip_q;
					mino_q  <= min_q;
					maxo_q  <= max_q;
					cnto_q  <= fill_new;
					ovfo_q  <= ovf_q;
					ivo_q   <= 1'b0;
				end
				OP_EMPTY: begin
					kind_q  <= 1'b0;
					peako_q <= '0;
					rmso_q  <= '0;
					dbfso_q <= DB_FLOOR;
					clipo_q <= 1'b0;
					mino_q  <= '0;
					maxo_q  <= '0;
					cnto_q  <= fill_q;
					ovfo_q  <= 1'b0;
					ivo_q   <= 1'b0;
				end
				default: begin
					kind_q  <= 1'b1;
					peako_q <= mpeak_q;
					rmso_q  <= mrms_q;
					dbfso_q <= mdbfs_q;
					clipo_q <= mclip_q;
					mino_q  <= rd_ok_q ? $signed(rd_q[31:16]) : 16'sd0;
					maxo_q  <= rd_ok_q ? $signed(rd_q[15:0]) : 16'sd0;
					cnto_q  <= fill_q;
					ovfo_q  <= 1'b0;
					ivo_q   <= rd_ok_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire && op_q == OP_SAMPLE) mem_q[wpos] <= {min_q, max_q};
		rd_q <= mem_q[head_q + idx_q];
	end

	assign out_valid      = ov_q;
	assign result_kind    = kind_q;
	assign peak           = peako_q;
	assign rms            = rmso_q;
	assign dbfs           = dbfso_q;
	assign clipping       = clipo_q;
	assign envelope_min   = mino_q;
	assign envelope_max   = maxo_q;
	assign history_count  = cnto_q;
	assign chunk_overflow = ovfo_q;
	assign index_valid    = ivo_q;

endmodule

// ===== hdl/acm_checker.sv =====
// Port-level checker of the audio chunk level meter, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module acm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic               result_kind,
	input logic [15:0]        peak,
	input logic signed [15:0] dbfs,
	input logic signed [15:0] envelope_min,
	input logic signed [15:0] envelope_max,
	input logic [10:0]        history_count,
	input logic               index_valid
);

	`ACM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(peak) && $stable(dbfs), "result changed while stalled")
	`ACM_ASSERT_SAME(a_floor_db, clk, arst_n, out_valid && peak == 16'd0, dbfs == -16'sd25600, "zero peak must read as the dB floor")
	`ACM_ASSERT_SAME(a_bad_index, clk, arst_n, out_valid && result_kind && !index_valid, envelope_min == 16'sd0 && envelope_max == 16'sd0, "invalid read must give zero envelope")
	`ACM_ASSERT_SAME(a_count_max, clk, arst_n, out_valid, history_count <= 11'd1024 && dbfs <= 16'sd0, "history count or level out of range")

endmodule

bind audio_chunk_level_meter acm_checker u_acm_checker (.*);

// ===== test/testbench.sv =====
// Self-checking testbench of the audio chunk level meter: directed and random requests.
// Depends on acm_pkg and audio_chunk_level_meter; checks every result against a local model.
`timescale 1ns / 1ps

module testbench;
	import acm_pkg::*;

	typedef struct packed {
		logic               kind;
		logic [15:0]        peak;
		logic [15:0]        rms;
		logic signed [15:0] dbfs;
		logic               clip;
		logic signed [15:0] env_min;
		logic signed [15:0] env_max;
		logic [10:0]        count;
		logic               overflow;
		logic               valid_idx;
	} meter_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         operation;
	logic signed [15:0] sample;
	logic               last_in_chunk;
	logic [9:0]         read_index;
	logic               out_valid;
	logic               out_ready;
	logic               result_kind;
	logic [15:0]        peak;
	logic [15:0]        rms;
	logic signed [15:0] dbfs;
	logic               clipping;
	logic signed [15:0] envelope_min;
	logic signed [15:0] envelope_max;
	logic [10:0]        history_count;
	logic               chunk_overflow;
	logic               index_valid;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [15:0]        cfg_data;

	// Local copy of the meter state.
	int unsigned     lim_reg;
	int unsigned     clip_reg;
	int unsigned     chunk_peak;
	longint unsigned chunk_sq;
	int              chunk_min;
	int              chunk_max;
	int unsigned     chunk_len;
	bit              chunk_ovf;
	int              ring_min [HistDepth];
	int              ring_max [HistDepth];
	int unsigned     ring_head;
	int unsigned     ring_fill;
	meter_t          latest;

	meter_t pending_meters[$];
	int     mismatches;
	int     idle_pct;
	int     stall_pct;
	int     hold_req;
	int     hold_seen;
	int     hold_cnt;
	int     quiet_cycles;

	audio_chunk_level_meter u_top (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic signed [15:0] peak_dbfs(input int unsigned p);
		longint unsigned e;
		longint unsigned m;
		longint unsigned frac;
		longint unsigned l;
		longint unsigned d;
		longint unsigned mag;
		e = 0;
		frac = 0;
		if (p == 0) return DB_FLOOR;
		while ((p >> (e + 1)) != 0) e++;
		m = longint'(p) << (30 - e);
		for (int i = 0; i < 24; i++) begin
			m = (m * m) >> 30;
			frac <<= 1;
			if (m >= (64'd1 << 31)) begin
				frac |= 1;
				m >>= 1;
			end
		end
		l = (e << 24) | frac;
		d = 64'd15 << 24;
		if (l >= d) return 16'sd0;
		d -= l;
		mag = (d * 64'd101008905 + (64'd1 << 39)) >> 40;
		if (mag > 25600) return DB_FLOOR;
		return -16'(mag);
	endfunction

	function automatic void chunk_restart();
		chunk_peak = 0;
		chunk_sq = 0;
		chunk_min = 32767;
		chunk_max = -32768;
		chunk_len = 0;
		chunk_ovf = 1'b0;
	endfunction

	function automatic void floor_latest();
		latest = '0;
		latest.dbfs = DB_FLOOR;
	endfunction

	function automatic void queue_meter(input meter_t r);
		pending_meters.insert(pending_meters.size(), r);
	endfunction

	function automatic meter_t meter_view(input logic k);
		meter_t r;
		r = latest;
		r.kind = k;
		r.env_min = '0;
		r.env_max = '0;
		r.overflow = 1'b0;
		r.valid_idx = 1'b0;
		r.count = 11'(ring_fill);
		return r;
	endfunction

	// Applies one accepted request to the local state and queues any result.
	function automatic void model_request(input op_t op, input logic signed [15:0] s,
			input logic lst, input logic [9:0] idx);
		meter_t r;
		int unsigned mag;
		int unsigned lim;
		int unsigned pos;
		case (op)
			OP_SAMPLE: begin
				if (chunk_len < 4096) begin
					mag = (s < 0) ? -int'(s) : int'(s);
					if (mag > chunk_peak) chunk_peak = mag;
					chunk_sq += longint'(mag) * mag;
					if (s < chunk_min) chunk_min = s;
					if (s > chunk_max) chunk_max = s;
					chunk_len++;
				end else begin
					chunk_ovf = 1'b1;
				end
				if (lst) begin
					latest.peak = 16'(chunk_peak);
					latest.rms = chunk_len ? 16'(int_sqrt(chunk_sq / chunk_len)) : 16'd0;
					latest.dbfs = peak_dbfs(chunk_peak);
					latest.clip = chunk_peak >= clip_reg;
					lim = (lim_reg > HistDepth) ? HistDepth : lim_reg;
					if (ring_fill >= HistDepth) begin
						pos = ring_head;
						ring_head = (ring_head + 1) % HistDepth;
					end else begin
						pos = (ring_head + ring_fill) % HistDepth;
						ring_fill++;
					end
					ring_min[pos] = chunk_min;
					ring_max[pos] = chunk_max;
					while (ring_fill > lim) begin
						ring_head = (ring_head + 1) % HistDepth;
						ring_fill--;
					end
					r = meter_view(1'b0);
					r.env_min = 16'(chunk_min);
					r.env_max = 16'(chunk_max);
					r.overflow = chunk_ovf;
					chunk_restart();
					queue_meter(r);
				end
			end
			OP_EMPTY: begin
				floor_latest();
				chunk_restart();
				queue_meter(meter_view(1'b0));
			end
			OP_CLEAR: begin
				ring_head = 0;
				ring_fill = 0;
				floor_latest();
			end
			default: begin
				r = meter_view(1'b1);
				if (idx < ring_fill) begin
					pos = (ring_head + idx) % HistDepth;
					r.env_min = 16'(ring_min[pos]);
					r.env_max = 16'(ring_max[pos]);
					r.valid_idx = 1'b1;
				end
				queue_meter(r);
			end
		endcase
	endfunction

	// Offers one request, leaving valid high on return.
	task automatic send_request(input op_t op, input logic signed [15:0] s,
			input logic lst, input logic [9:0] idx);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			operation <= 2'($urandom);
			sample <= 16'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		sample <= s;
		last_in_chunk <= lst;
		read_index <= idx;
		do @(posedge clk); while (!(in_valid && in_ready));
		model_request(op, s, lst, idx);
	endtask

	task automatic release_input();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		release_input();
		wait (pending_meters.size() == 0);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_register(input cfg_idx_t i, input logic [15:0] v);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= i;
		cfg_data <= v;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		if (i == CFG_HIST_LIMIT) lim_reg = v & 16'h7FF;
		else if (i == CFG_CLIP_THR) clip_reg = v;
	endtask

	task automatic send_chunk(input int len);
		for (int i = 0; i < len; i++)
			send_request(OP_SAMPLE, 16'($urandom), i == len - 1, 10'($urandom));
	endtask

	task automatic test_directed();
		send_request(OP_READ, 0, 0, 10'd0);
		send_request(OP_SAMPLE, -16'sd32768, 0, 0);
		send_request(OP_SAMPLE, 16'sd32767, 1, 0);
		send_request(OP_SAMPLE, 16'sd0, 1, 0);
		send_request(OP_SAMPLE, 16'sd1, 0, 0);
		send_request(OP_SAMPLE, -16'sd1, 1, 0);
		send_request(OP_SAMPLE, 16'sd32736, 1, 0);
		send_request(OP_SAMPLE, 16'sd32735, 1, 0);
		send_request(OP_READ, 0, 0, 10'd0);
		send_request(OP_READ, 0, 0, 10'd5);
		send_request(OP_READ, 0, 0, 10'd1023);
		send_request(OP_SAMPLE, 16'sd1234, 0, 0);
		send_request(OP_EMPTY, 0, 0, 0);
		send_request(OP_SAMPLE, -16'sd77, 0, 0);
		send_request(OP_CLEAR, 0, 0, 0);
		send_request(OP_READ, 0, 0, 10'd0);
		send_request(OP_SAMPLE, 16'sd500, 1, 0);
		send_request(OP_READ, 0, 0, 10'd0);
		send_request(OP_READ, 0, 0, 10'd1);
	endtask

	task automatic test_limits();
		write_register(CFG_HIST_LIMIT, 16'd0);
		write_register(CFG_CLIP_THR, 16'd0);
		send_chunk(3);
		send_request(OP_READ, 0, 0, 10'd0);
		send_request(OP_EMPTY, 0, 0, 0);
		write_register(CFG_HIST_LIMIT, 16'd2047);
		write_register(CFG_CLIP_THR, 16'd32768);
		send_request(OP_SAMPLE, -16'sd32768, 1, 0);
		send_request(OP_SAMPLE, 16'sd32767, 1, 0);
		write_register(CFG_HIST_LIMIT, 16'd3);
		write_register(cfg_idx_t'(2'd2), 16'hFFFF);
		write_register(cfg_idx_t'(2'd3), 16'h0001);
		send_chunk(2);
		for (int i = 0; i < 5; i++) send_request(OP_READ, 0, 0, 10'(i));
		write_register(CFG_HIST_LIMIT, 16'd1);
		send_chunk(1);
		send_request(OP_READ, 0, 0, 10'd0);
		send_request(OP_READ, 0, 0, 10'd1);
	endtask

	task automatic test_random(input int n, input int idle, input int stall);
		int sent;
		int pick;
		idle_pct = idle;
		stall_pct = stall;
		sent = 0;
		while (sent < n) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				pick = ($urandom_range(9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 8);
				send_chunk(pick);
				sent += pick;
			end else begin
				if (pick < 85)
					send_request(OP_READ, 0, 0, ($urandom_range(3) == 0) ?
						10'($urandom) : 10'($urandom_range(ring_fill + 1)));
				else if (pick < 90)
					send_request(OP_EMPTY, 16'($urandom), 1'($urandom), 10'($urandom));
				else if (pick < 94)
					send_request(OP_CLEAR, 16'($urandom), 1'($urandom), 10'($urandom));
				else
					send_request(OP_SAMPLE, 16'($urandom), 1'($urandom), 10'($urandom));
				sent++;
			end
		end
		idle_pct = 0;
		stall_pct = 0;
	endtask

	task automatic test_back_pressure();
		hold_req++;
		for (int i = 0; i < 40; i++)
			send_request(($urandom_range(1) == 0) ? OP_READ : OP_EMPTY, 0, 0, 10'($urandom));
	endtask

	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_cnt <= 400;
			out_ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		meter_t got;
		meter_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{result_kind, peak, rms, dbfs, clipping, envelope_min, envelope_max,
				history_count, chunk_overflow, index_valid};
			if (pending_meters.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected result: %p", got);
			end else begin
				want = pending_meters[0];
				pending_meters.delete(0);
				if (got.kind !== want.kind || got.peak !== want.peak ||
						got.rms !== want.rms || got.dbfs !== want.dbfs ||
						got.clip !== want.clip || got.env_min !== want.env_min ||
						got.env_max !== want.env_max || got.count !== want.count ||
						got.overflow !== want.overflow || got.valid_idx !== want.valid_idx) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected %p, actual %p", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_SAMPLE;
		sample = '0;
		last_in_chunk = 1'b0;
		read_index = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_HIST_LIMIT;
		cfg_data = '0;
		mismatches = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 0;
		hold_seen = 0;
		hold_cnt = 0;
		quiet_cycles = 0;
		lim_reg = 1024;
		clip_reg = 32736;
		ring_head = 0;
		ring_fill = 0;
		chunk_restart();
		floor_latest();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_limits();
		write_register(CFG_HIST_LIMIT, 16'd40);
		write_register(CFG_CLIP_THR, 16'd20000);
		test_random(250, 0, 0);
		test_random(200, 84, 0);
		write_register(CFG_HIST_LIMIT, 16'd1024);
		test_random(200, 0, 84);
		test_back_pressure();
		write_register(CFG_CLIP_THR, 16'd32736);
		test_random(220, 12, 12);
		wait_drained();
		if (mismatches == 0 && pending_meters.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== audio_chunk_level_meter.f =====
+incdir+hdl
hdl/acm_pkg.sv
hdl/acm_math.sv
hdl/audio_chunk_level_meter.sv
hdl/acm_checker.sv
test/testbench.sv
